// File: design/slboc_pkg.sv
// ----------------------------------------------------------------------------
// slboc_pkg
// Shared constants, command codes and controller/datapath link types for the
// status LED blink and override controller.
// ----------------------------------------------------------------------------
package slboc_pkg;

    // number of LEDs by default, and how many of them a 3-bit pixel can reach
    localparam int NUM_LEDS_DEF  = 8;
    localparam int LED_ADDR_MAX  = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 3;
    localparam int COLOR_W = 24;
    localparam int STYLE_W = 2;
    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 8;
    localparam int PER_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD  = 2'd2;

    localparam logic [PER_W-1:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [PER_W-1:0] FAST_PERIOD_RST = 16'd250;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_BASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_OVR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    // style codes
    localparam logic [STYLE_W-1:0] STYLE_STEADY = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_SLOW   = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_FAST   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic now_inc;
        logic clr_changed;
        logic exp_step;
        logic blk_step;
        logic set_base;
        logic set_ovr;
        logic emit_beat;
        logic idx_clr;
        logic idx_inc;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pix_ok;
        logic             show;
        logic             last_store;
        logic             last_led;
        logic             changed;
        logic             out_free;
    } t_dp_stat;

endpackage

// File: design/slboc_ctrl.sv
// ----------------------------------------------------------------------------
// slboc_ctrl
// Sequencer: decodes a command; a tick walks the LEDs for expiry and blink
// updates, then, when a refresh is due, the LEDs are walked again beat by beat.
// ----------------------------------------------------------------------------
module slboc_ctrl
    import slboc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXP,
        S_BLK,
        S_TICK_END,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_TICK: begin
                        o_cmd.now_inc     = 1'b1;
                        o_cmd.clr_changed = 1'b1;
                        o_cmd.idx_clr     = 1'b1;
                        n_state           = S_EXP;
                    end
                    CMD_SET_BASE: begin
                        o_cmd.set_base = i_stat.pix_ok;
                        o_cmd.idx_clr  = 1'b1;
                        n_state        = (i_stat.pix_ok && i_stat.show) ? S_EMIT : S_IDLE;
                    end
                    CMD_SET_OVR: begin
                        o_cmd.set_ovr = i_stat.pix_ok;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = i_stat.pix_ok ? S_EMIT : S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                n_state        = S_BLK;
            end
            S_BLK: begin
                o_cmd.blk_step = 1'b1;
                if (i_stat.last_store) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_TICK_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_EXP;
                end
            end
            S_TICK_END: begin
                n_state = i_stat.changed ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_beat = 1'b1;
                    if (i_stat.last_led) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// File: design/slboc_dp.sv
// ----------------------------------------------------------------------------
// slboc_dp
// Datapath: millisecond counter, per-LED base and override state, config
// registers, LED index counter and the output beat register.
// ----------------------------------------------------------------------------
module slboc_dp
    import slboc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [STYLE_W-1:0]    i_style,
    input  logic                  i_show_now,
    input  logic [TIME_W-1:0]     i_duration_ms,
    input  logic                  i_clear_on_change,
    input  t_dp_cmd               i_dcmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [PIX_W-1:0]      o_led_index,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    output logic                  o_last
);

    // only the LEDs a pixel number can reach hold state; the rest stay black
    localparam int STORE = (NUM_LEDS < LED_ADDR_MAX) ? NUM_LEDS : LED_ADDR_MAX;
    localparam int IW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SW    = (STORE > 1) ? $clog2(STORE) : 1;

    // config
    logic             r_common_anode;
    logic [PER_W-1:0] r_slow_period;
    logic [PER_W-1:0] r_fast_period;

    // latched command
    logic [CMD_W-1:0]   r_cmd;
    logic [PIX_W-1:0]   r_pixel;
    logic [COLOR_W-1:0] r_color;
    logic [STYLE_W-1:0] r_style;
    logic               r_show;
    logic [TIME_W-1:0]  r_dur;
    logic               r_clr;

    logic [TIME_W-1:0]  r_now;
    logic               r_changed;
    logic [IW-1:0]      r_idx;
    logic               r_out_valid;

    // output beat
    logic [PIX_W-1:0]   r_led_index;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;
    logic               r_last;

    logic [COLOR_W-1:0] r_base_color [STORE];
    logic [STYLE_W-1:0] r_base_style [STORE];
    logic [TIME_W-1:0]  r_base_last  [STORE];
    logic               r_base_phase [STORE];
    logic [TIME_W-1:0]  r_ovr_start  [STORE];
    logic [TIME_W-1:0]  r_ovr_len    [STORE];
    logic [COLOR_W-1:0] r_ovr_color  [STORE];
    logic [STYLE_W-1:0] r_ovr_style  [STORE];
    logic [TIME_W-1:0]  r_ovr_last   [STORE];
    logic               r_ovr_phase  [STORE];
    logic               r_ovr_clr    [STORE];

    logic [SW-1:0]      li;
    logic [SW-1:0]      pi;
    logic               in_store;
    logic               ovr_act;
    logic               exp_hit;
    logic [TIME_W-1:0]  ovr_age;
    logic [STYLE_W-1:0] act_style;
    logic [TIME_W-1:0]  act_last;
    logic               act_phase;
    logic [COLOR_W-1:0] act_color;
    logic [PER_W-1:0]   period;
    logic               blinks;
    logic [TIME_W-1:0]  since_toggle;
    logic               blk_hit;
    logic [COLOR_W-1:0] shown;
    logic [COLOR_W-1:0] drive;
    logic               out_free;

    assign li       = r_idx[SW-1:0];
    assign pi       = r_pixel[SW-1:0];
    assign in_store = ({1'b0, r_idx} < (IW+1)'(STORE));

    // state of the LED under the index
    always_comb begin
        ovr_act   = (r_ovr_len[li] != '0);
        ovr_age   = r_now - r_ovr_start[li];
        exp_hit   = ovr_act && (ovr_age >= r_ovr_len[li]);
        act_style = ovr_act ? r_ovr_style[li] : r_base_style[li];
        act_last  = ovr_act ? r_ovr_last[li]  : r_base_last[li];
        act_phase = ovr_act ? r_ovr_phase[li] : r_base_phase[li];
        act_color = ovr_act ? r_ovr_color[li] : r_base_color[li];
        case (act_style)
            STYLE_SLOW: begin
                period = r_slow_period;
                blinks = 1'b1;
            end
            STYLE_FAST: begin
                period = r_fast_period;
                blinks = 1'b1;
            end
            default: begin
                period = r_slow_period;
                blinks = 1'b0;
            end
        endcase
        since_toggle = r_now - act_last;
        blk_hit      = blinks && (since_toggle >= {{(TIME_W-PER_W){1'b0}}, period});
        // blink-off phase shows black; steady shows its colour
        if (in_store && (act_style == STYLE_STEADY || act_phase)) begin
            shown = act_color;
        end else begin
            shown = '0;
        end
        drive = r_common_anode ? ~shown : shown;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_anode <= 1'b0;
            r_slow_period  <= SLOW_PERIOD_RST;
            r_fast_period  <= FAST_PERIOD_RST;
            r_now          <= '0;
            r_changed      <= 1'b0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < STORE; k++) begin
                r_base_color[k] <= '0;
                r_base_style[k] <= STYLE_STEADY;
                r_base_last[k]  <= '0;
                r_base_phase[k] <= 1'b0;
                r_ovr_start[k]  <= '0;
                r_ovr_len[k]    <= '0;
                r_ovr_color[k]  <= '0;
                r_ovr_style[k]  <= STYLE_STEADY;
                r_ovr_last[k]   <= '0;
                r_ovr_phase[k]  <= 1'b0;
                r_ovr_clr[k]    <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COMMON_ANODE: r_common_anode <= i_cfg_data[0];
                    CFG_SLOW_PERIOD:  r_slow_period  <= i_cfg_data[PER_W-1:0];
                    CFG_FAST_PERIOD:  r_fast_period  <= i_cfg_data[PER_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_dcmd.now_inc) begin
                r_now <= r_now + 1'b1;
            end
            if (i_dcmd.clr_changed) begin
                r_changed <= 1'b0;
            end

            if (i_dcmd.exp_step && exp_hit) begin
                r_ovr_len[li] <= '0;
                r_changed     <= 1'b1;
            end

            if (i_dcmd.blk_step && blk_hit) begin
                r_changed <= 1'b1;
                if (ovr_act) begin
                    r_ovr_last[li]  <= r_now;
                    r_ovr_phase[li] <= ~r_ovr_phase[li];
                end else begin
                    r_base_last[li]  <= r_now;
                    r_base_phase[li] <= ~r_base_phase[li];
                end
            end

            if (i_dcmd.set_base) begin
                r_base_color[pi] <= r_color;
                r_base_style[pi] <= r_style;
                if (r_ovr_len[pi] != '0 && r_ovr_clr[pi]) begin
                    r_ovr_len[pi] <= '0;
                end
            end

            if (i_dcmd.set_ovr) begin
                r_ovr_start[pi] <= r_now;
                r_ovr_len[pi]   <= r_dur;
                r_ovr_color[pi] <= r_color;
                r_ovr_style[pi] <= r_style;
                r_ovr_last[pi]  <= '0;
                r_ovr_phase[pi] <= 1'b0;
                r_ovr_clr[pi]   <= r_clr;
            end

            if (i_dcmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_dcmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_dcmd.emit_beat) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_dcmd.latch_in) begin
            r_cmd   <= i_cmd;
            r_pixel <= i_pixel;
            r_color <= i_color;
            r_style <= i_style;
            r_show  <= i_show_now;
            r_dur   <= i_duration_ms;
            r_clr   <= i_clear_on_change;
        end
        if (i_dcmd.emit_beat) begin
            r_led_index <= PIX_W'(r_idx);
            r_red       <= drive[23:16];
            r_green     <= drive[15:8];
            r_blue      <= drive[7:0];
            r_last      <= (r_idx == IW'(NUM_LEDS - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_led_index;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_last      = r_last;

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.pix_ok     = ({4'b0, r_pixel} < 7'(NUM_LEDS));
        o_stat.show       = r_show;
        o_stat.last_store = (r_idx == IW'(STORE - 1));
        o_stat.last_led   = (r_idx == IW'(NUM_LEDS - 1));
        o_stat.changed    = r_changed;
        o_stat.out_free   = out_free;
    end

endmodule

// File: design/status_led_blink_override_controller_unit.sv
// ----------------------------------------------------------------------------
// status_led_blink_override_controller_unit
// Per-LED base colour/style with timed overrides, blink timing and refresh.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one command beat: a 1 ms tick,
// a base set or an override set. Output channel (o_out_valid / i_out_stall)
// gives a refresh of NUM_LEDS beats, LED 0 first, o_last on the final one.
// Commands are handled one at a time. A set command is followed by a refresh
// when one is due. A tick first gives each of the M = min(NUM_LEDS, 8)
// addressable LEDs an override expiry step and then a blink check; if any
// override expired or any blink phase toggled, a refresh follows.
// LEDs beyond the eighth cannot be addressed and always show black.
// The output beat sits in a register: while the receiver stalls the refresh
// walk waits on it, and the next command may be accepted as soon as the final
// beat is loaded. Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect
// at once and belong in idle time. Synchronous active-low reset clears all
// LED state and the ms counter, sets periods to 1000 and 250 ms, drops valid.
// ----------------------------------------------------------------------------
module status_led_blink_override_controller_unit
    import slboc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [STYLE_W-1:0]    i_style,
    input  logic                  i_show_now,
    input  logic [TIME_W-1:0]     i_duration_ms,
    input  logic                  i_clear_on_change,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_led_index,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    output logic                  o_last
);

    t_dp_cmd  dcmd;
    t_dp_stat dstat;

    slboc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dstat),
        .o_cmd      (dcmd)
    );

    slboc_dp #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_pixel           (i_pixel),
        .i_color           (i_color),
        .i_style           (i_style),
        .i_show_now        (i_show_now),
        .i_duration_ms     (i_duration_ms),
        .i_clear_on_change (i_clear_on_change),
        .i_dcmd            (dcmd),
        .o_stat            (dstat),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_led_index       (o_led_index),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_last            (o_last)
    );

endmodule

// File: verif/slboc_refresh_checker.sv
// ----------------------------------------------------------------------------
// slboc_refresh_checker
// Watches the command and refresh channels of the status LED controller,
// keeps its own copy of the LED, override and timer state, works out the
// refresh beats each accepted command should cause and compares every
// accepted output beat with the oldest one still owed.
// ----------------------------------------------------------------------------
module slboc_refresh_checker
    import slboc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic [STYLE_W-1:0]    i_style,
    input  logic                  i_show_now,
    input  logic [TIME_W-1:0]     i_duration_ms,
    input  logic                  i_clear_on_change,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PIX_W-1:0]      i_led_index,
    input  logic [CHAN_W-1:0]     i_red,
    input  logic [CHAN_W-1:0]     i_green,
    input  logic [CHAN_W-1:0]     i_blue,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [PIX_W-1:0]  led;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_led_drive;

    t_led_drive refresh_q[$];

    // register copies
    logic              anode_mode;
    logic [PER_W-1:0]  slow_ms;
    logic [PER_W-1:0]  fast_ms;

    // per LED state
    logic [TIME_W-1:0]  ms_count;
    logic [COLOR_W-1:0] base_rgb     [NUM_LEDS];
    logic [STYLE_W-1:0] base_mode    [NUM_LEDS];
    logic [TIME_W-1:0]  base_toggled [NUM_LEDS];
    logic               base_lit     [NUM_LEDS];
    logic [TIME_W-1:0]  ovr_from     [NUM_LEDS];
    logic [TIME_W-1:0]  ovr_len      [NUM_LEDS];
    logic [COLOR_W-1:0] ovr_rgb      [NUM_LEDS];
    logic [STYLE_W-1:0] ovr_mode     [NUM_LEDS];
    logic [TIME_W-1:0]  ovr_toggled  [NUM_LEDS];
    logic               ovr_lit      [NUM_LEDS];
    logic               ovr_drop     [NUM_LEDS];

    function automatic logic toggle_due(input logic [STYLE_W-1:0] mode,
                                        input logic [TIME_W-1:0] toggled);
        logic [TIME_W-1:0] elapsed;
        logic [PER_W-1:0]  period;
        elapsed = ms_count - toggled;
        if (mode == STYLE_SLOW) begin
            period = slow_ms;
        end else if (mode == STYLE_FAST) begin
            period = fast_ms;
        end else begin
            return 1'b0;
        end
        return elapsed >= TIME_W'(period);
    endfunction

    function automatic logic [COLOR_W-1:0] visible_color(input int i);
        logic [COLOR_W-1:0] rgb;
        logic [STYLE_W-1:0] mode;
        logic               lit;
        rgb  = base_rgb[i];
        mode = base_mode[i];
        lit  = base_lit[i];
        if (ovr_len[i] != '0) begin
            rgb  = ovr_rgb[i];
            mode = ovr_mode[i];
            lit  = ovr_lit[i];
        end
        // blink off phase shows black unless the style is steady
        if (mode == STYLE_STEADY || lit) begin
            return rgb;
        end
        return '0;
    endfunction

    task automatic queue_refresh();
        logic [COLOR_W-1:0] rgb;
        t_led_drive         beat;
        for (int i = 0; i < NUM_LEDS; i++) begin
            rgb        = visible_color(i);
            beat.led   = PIX_W'(i);
            beat.red   = rgb[23:16];
            beat.green = rgb[15:8];
            beat.blue  = rgb[7:0];
            if (anode_mode) begin
                beat.red   = ~beat.red;
                beat.green = ~beat.green;
                beat.blue  = ~beat.blue;
            end
            beat.last = (i == NUM_LEDS - 1);
            refresh_q.push_back(beat);
        end
    endtask

    task automatic apply_command(input logic [CMD_W-1:0]   cmd,
                                 input logic [PIX_W-1:0]   pix,
                                 input logic [COLOR_W-1:0] rgb,
                                 input logic [STYLE_W-1:0] mode,
                                 input logic               show,
                                 input logic [TIME_W-1:0]  dur,
                                 input logic               drop);
        logic changed;
        changed = 1'b0;
        if (cmd == CMD_TICK) begin
            ms_count = ms_count + 1'b1;
            // expiry is settled for every LED before any blink check
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (ovr_len[i] != '0 && (ms_count - ovr_from[i]) >= ovr_len[i]) begin
                    ovr_len[i] = '0;
                    changed    = 1'b1;
                end
            end
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (ovr_len[i] != '0) begin
                    if (toggle_due(ovr_mode[i], ovr_toggled[i])) begin
                        ovr_toggled[i] = ms_count;
                        ovr_lit[i]     = ~ovr_lit[i];
                        changed        = 1'b1;
                    end
                end else if (toggle_due(base_mode[i], base_toggled[i])) begin
                    base_toggled[i] = ms_count;
                    base_lit[i]     = ~base_lit[i];
                    changed         = 1'b1;
                end
            end
            if (changed) begin
                queue_refresh();
            end
        end else if (cmd != CMD_UNUSED && int'(pix) < NUM_LEDS) begin
            if (cmd == CMD_SET_BASE) begin
                base_rgb[pix]  = rgb;
                base_mode[pix] = mode;
                if (ovr_len[pix] != '0 && ovr_drop[pix]) begin
                    ovr_len[pix] = '0;
                end
                if (show) begin
                    queue_refresh();
                end
            end else begin
                ovr_from[pix]    = ms_count;
                ovr_len[pix]     = dur;
                ovr_rgb[pix]     = rgb;
                ovr_mode[pix]    = mode;
                ovr_toggled[pix] = '0;
                ovr_lit[pix]     = 1'b0;
                ovr_drop[pix]    = drop;
                queue_refresh();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_led_drive got;
        t_led_drive want;
        if (!i_rst_n) begin
            anode_mode = 1'b0;
            slow_ms    = SLOW_PERIOD_RST;
            fast_ms    = FAST_PERIOD_RST;
            ms_count   = '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                base_rgb[i]     = '0;
                base_mode[i]    = STYLE_STEADY;
                base_toggled[i] = '0;
                base_lit[i]     = 1'b0;
                ovr_from[i]     = '0;
                ovr_len[i]      = '0;
                ovr_rgb[i]      = '0;
                ovr_mode[i]     = STYLE_STEADY;
                ovr_toggled[i]  = '0;
                ovr_lit[i]      = 1'b0;
                ovr_drop[i]     = 1'b0;
            end
            refresh_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COMMON_ANODE: anode_mode = i_cfg_data[0];
                    CFG_SLOW_PERIOD:  slow_ms    = i_cfg_data;
                    CFG_FAST_PERIOD:  fast_ms    = i_cfg_data;
                    default: ;
                endcase
            end
            // check the outgoing beat before this edge's command adds to the queue
            if (i_out_valid && !i_out_stall) begin
                o_beats_seen++;
                got = '{i_led_index, i_red, i_green, i_blue, i_last};
                if (refresh_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("%t: refresh beat with none owed:",
                                 $realtime);
                        $display("%t:   got led %0d rgb %02h%02h%02h last %b",
                                 $realtime, got.led, got.red, got.green, got.blue,
                                 got.last);
                    end
                end else begin
                    want = refresh_q.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("%t: refresh beat mismatch:", $realtime);
                            $display("%t:   expected led %0d rgb %02h%02h%02h last %b",
                                     $realtime, want.led, want.red, want.green,
                                     want.blue, want.last);
                            $display("%t:   got      led %0d rgb %02h%02h%02h last %b",
                                     $realtime, got.led, got.red, got.green, got.blue,
                                     got.last);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_cmd, i_pixel, i_color, i_style, i_show_now, i_duration_ms,
                              i_clear_on_change);
            end
        end
        o_pending = refresh_q.size();
    end

endmodule

// File: verif/status_led_blink_override_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// status_led_blink_override_controller_unit_tb
// Drives ticks, base sets, override sets and unused commands into the LED
// controller under several register settings, with random gaps on both
// channels and one long output hold-off, and leaves the checking of every
// refresh beat to the refresh checker beside the block.
// ----------------------------------------------------------------------------
module status_led_blink_override_controller_unit_tb;
    import slboc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS      = NUM_LEDS_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 80;

    localparam logic [STYLE_W-1:0] STYLE_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PIX_W-1:0]   pixel;
        logic [COLOR_W-1:0] color;
        logic [STYLE_W-1:0] style;
        logic               show_now;
        logic [TIME_W-1:0]  duration;
        logic               clear_flag;
    } t_led_cmd;

    localparam t_led_cmd ONE_MS_TICK = '{CMD_TICK, '0, '0, STYLE_STEADY, 1'b0, '0, 1'b0};

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd             = '0;
    logic [PIX_W-1:0]      i_pixel           = '0;
    logic [COLOR_W-1:0]    i_color           = '0;
    logic [STYLE_W-1:0]    i_style           = '0;
    logic                  i_show_now        = 1'b0;
    logic [TIME_W-1:0]     i_duration_ms     = '0;
    logic                  i_clear_on_change = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall       = 1'b0;
    logic [PIX_W-1:0]      o_led_index;
    logic [CHAN_W-1:0]     o_red;
    logic [CHAN_W-1:0]     o_green;
    logic [CHAN_W-1:0]     o_blue;
    logic                  o_last;

    int fail_total;
    int beats_owed;
    int beats_checked;
    int quiet_cycles;
    int ticks_sent;
    int base_sent;
    int ovr_sent;
    int ignored_sent;

    bit send_gaps    = 1'b1;
    bit stall_bursts = 1'b1;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    status_led_blink_override_controller_unit #(.NUM_LEDS(NUM_LEDS)) uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_cmd, .i_pixel, .i_color, .i_style,
        .i_show_now, .i_duration_ms, .i_clear_on_change,
        .o_out_valid, .i_out_stall, .o_led_index, .o_red, .o_green, .o_blue, .o_last
    );

    slboc_refresh_checker #(.NUM_LEDS(NUM_LEDS)) u_refresh_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_cmd, .i_pixel, .i_color, .i_style,
        .i_show_now, .i_duration_ms, .i_clear_on_change,
        .i_out_valid(o_out_valid), .i_out_stall, .i_led_index(o_led_index),
        .i_red(o_red), .i_green(o_green), .i_blue(o_blue), .i_last(o_last),
        .o_fail_count(fail_total), .o_pending(beats_owed), .o_beats_seen(beats_checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timed out after %0d quiet cycles", QUIET_LIMIT);
            $display("status_led_blink_override_controller_unit_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (stall_bursts && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_cmd(input t_led_cmd item);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cmd             <= item.cmd;
        i_pixel           <= item.pixel;
        i_color           <= item.color;
        i_style           <= item.style;
        i_show_now        <= item.show_now;
        i_duration_ms     <= item.duration;
        i_clear_on_change <= item.clear_flag;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        case (item.cmd)
            CMD_TICK:     ticks_sent++;
            CMD_SET_BASE: base_sent++;
            CMD_SET_OVR:  ovr_sent++;
            default:      ignored_sent++;
        endcase
    endtask

    // a tick or base set with nothing to show leaves the block busy for a while
    task automatic drain();
        i_in_valid <= 1'b0;
        while (beats_owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic anode, input logic [PER_W-1:0] slow,
                              input logic [PER_W-1:0] fast);
        drain();
        write_reg(CFG_COMMON_ANODE, CFG_DATA_W'(anode));
        write_reg(CFG_SLOW_PERIOD, slow);
        write_reg(CFG_FAST_PERIOD, fast);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_led_cmd random_cmd();
        t_led_cmd item;
        int       pick;
        pick            = $urandom_range(0, 99);
        item.pixel      = PIX_W'($urandom_range(0, 7));
        item.color      = COLOR_W'($urandom);
        item.style      = STYLE_W'($urandom_range(0, 3));
        item.show_now   = 1'($urandom_range(0, 1));
        item.clear_flag = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       item.duration = '0;
            1:       item.duration = '1;
            2:       item.duration = TIME_W'($urandom);
            default: item.duration = TIME_W'($urandom_range(1, 30));
        endcase
        if (pick < 50) begin
            item.cmd = CMD_TICK;
        end else if (pick < 72) begin
            item.cmd = CMD_SET_BASE;
        end else if (pick < 95) begin
            item.cmd = CMD_SET_OVR;
        end else begin
            item.cmd = CMD_UNUSED;
        end
        return item;
    endfunction

    task automatic run_random(input int count);
        repeat (count) push_cmd(random_cmd());
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset periods: nothing blinks yet, so only sets and override expiry refresh
        push_cmd(ONE_MS_TICK);
        push_cmd('{CMD_SET_BASE, 3'd0, 24'hFFFFFF, STYLE_STEADY, 1'b1, 32'd0, 1'b0});
        push_cmd('{CMD_SET_BASE, 3'd7, 24'h000000, STYLE_SLOW, 1'b0, 32'd0, 1'b0});
        push_cmd('{CMD_SET_BASE, 3'd3, 24'h123456, STYLE_UNUSED, 1'b1, 32'd0, 1'b0});
        push_cmd('{CMD_SET_OVR, 3'd1, 24'hFF0000, STYLE_FAST, 1'b0, 32'hFFFFFFFF, 1'b0});
        push_cmd('{CMD_SET_OVR, 3'd2, 24'h00FF00, STYLE_STEADY, 1'b1, 32'd0, 1'b1});
        push_cmd('{CMD_SET_OVR, 3'd4, 24'h0000FF, STYLE_STEADY, 1'b0, 32'd2, 1'b1});
        // base set drops the override that asked to be cleared
        push_cmd('{CMD_SET_BASE, 3'd4, 24'hAAAAAA, STYLE_STEADY, 1'b1, 32'd0, 1'b0});
        push_cmd('{CMD_SET_OVR, 3'd5, 24'h80FF01, STYLE_STEADY, 1'b0, 32'd3, 1'b0});
        push_cmd('{CMD_SET_BASE, 3'd5, 24'hFF00FF, STYLE_SLOW, 1'b0, 32'd0, 1'b1});
        push_cmd('{CMD_UNUSED, 3'd6, 24'hFFFFFF, STYLE_FAST, 1'b1, 32'hFFFFFFFF, 1'b1});
        // override on led 5 runs out during these
        repeat (4) push_cmd(ONE_MS_TICK);

        // period zero toggles every tick
        set_config(1'b1, 16'd1, 16'd0);
        push_cmd('{CMD_SET_OVR, 3'd6, 24'h00FF00, STYLE_FAST, 1'b0, 32'd5, 1'b1});
        push_cmd('{CMD_SET_BASE, 3'd2, 24'h55AA55, STYLE_UNUSED, 1'b1, 32'd0, 1'b0});
        repeat (4) push_cmd(ONE_MS_TICK);
        push_cmd('{CMD_SET_BASE, 3'd6, 24'h010203, STYLE_SLOW, 1'b1, 32'd0, 1'b0});
        run_random(PHASE_ITEMS);

        // long output hold-off while commands keep coming
        set_config(1'b0, 16'd3, 16'd2);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        set_config(1'b1, 16'hFFFF, 16'd1);
        run_random(PHASE_ITEMS);

        set_config(1'b0, 16'd0, 16'hFFFF);
        run_random(PHASE_ITEMS);

        // closing stretch with both sides flowing freely
        set_config(1'b0, 16'd4, 16'd2);
        send_gaps    = 1'b0;
        stall_bursts = 1'b0;
        run_random(PHASE_ITEMS);

        drain();
        $display("sent %0d ticks, %0d base sets, %0d override sets, %0d unused commands",
                 ticks_sent, base_sent, ovr_sent, ignored_sent);
        $display("checked %0d refresh beats over six register settings, one long hold-off",
                 beats_checked);
        if (fail_total == 0) begin
            $display("status_led_blink_override_controller_unit_tb: done, clean");
        end else begin
            $display("%0d refresh beat failures", fail_total);
            $display("status_led_blink_override_controller_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
